// ===== src/gpf_pkg.sv =====
`default_nettype none

package gpf_pkg;

  localparam int VALUE_BITS = 12;
  localparam int MAX_PAIRS  = 64;

  localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int IDX_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int DCNT_W = $clog2(VALUE_BITS + 1);
  localparam int SQ_W   = 2 * VALUE_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [SQ_W-1:0]       square_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [IDX_W-1:0]      index_t;
  typedef logic [DCNT_W-1:0]     div_count_t;

endpackage

`default_nettype wire

// ===== src/gpf_if.sv =====
`default_nettype none

interface gpf_in_if import gpf_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface gpf_out_if import gpf_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t number_echo;
  value_t small_prime;
  value_t large_prime;
  logic   found;
  logic   truncated;
  logic   last;

  modport source (output valid, output number_echo, output small_prime, output large_prime,
                  output found, output truncated, output last, input ready);
  modport sink   (input valid, input number_echo, input small_prime, input large_prime,
                  input found, input truncated, input last, output ready);
endinterface

`default_nettype wire

// ===== src/gpf_divider.sv =====
`default_nettype none

// restoring remainder, one quotient bit per cycle
module gpf_divider import gpf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  value_t dividend,
  input  value_t divisor,
  output logic   done,
  output value_t remainder
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  value_t                a_r, a_nxt;
  value_t                r_r, r_nxt;
  value_t                d_r, d_nxt;
  div_count_t            cnt_r, cnt_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  assign trial = {r_r, a_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      a_nxt   = {a_r[VALUE_BITS-2:0], 1'b0};
      r_nxt   = diff[VALUE_BITS] ? trial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == div_count_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = div_count_t'(VALUE_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done      = done_r;
  assign remainder = r_r;

endmodule

`default_nettype wire

// ===== src/gpf_prime_test.sv =====
`default_nettype none

// odd-prime test by trial division over odd divisors from 3
module gpf_prime_test import gpf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  value_t value,
  output logic   done,
  output logic   is_prime
);

  typedef enum logic [2:0] {
    PT_IDLE  = 3'b001,
    PT_CHECK = 3'b010,
    PT_WAIT  = 3'b100
  } pt_state_t;

  pt_state_t state_r, state_nxt;
  logic      done_r, done_nxt;
  logic      prime_r, prime_nxt;
  value_t    v_r, v_nxt;
  value_t    d_r, d_nxt;
  square_t   sq_r, sq_nxt;
  logic      div_start;
  logic      div_done;
  value_t    div_rem;

  gpf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (v_r),
    .divisor   (d_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    prime_nxt = prime_r;
    v_nxt     = v_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    div_start = 1'b0;
    case (state_r)
      PT_IDLE: begin
        if (start) begin
          v_nxt  = value;
          d_nxt  = value_t'(3);
          sq_nxt = square_t'(9);
          if (!value[0] || value == value_t'(1)) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
          end else begin
            state_nxt = PT_CHECK;
          end
        end
      end
      PT_CHECK: begin
        if (sq_r > square_t'(v_r)) begin
          done_nxt  = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = PT_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = PT_WAIT;
        end
      end
      PT_WAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = PT_IDLE;
          end else begin
            d_nxt     = d_r + value_t'(2);
            sq_nxt    = sq_r + square_t'({d_r, 2'b00}) + square_t'(4);
            state_nxt = PT_CHECK;
          end
        end
      end
      default: state_nxt = PT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PT_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    prime_r <= prime_nxt;
    v_r     <= v_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
  end

  assign done     = done_r;
  assign is_prime = prime_r;

endmodule

`default_nettype wire

// ===== src/goldbach_partition_finder.sv =====
`default_nettype none

// channel  direction  fields
// in_ch    sink       number
// out_ch   source     number_echo, small_prime, large_prime, found, truncated, last
// cfg_*    write      first_only (cfg_wdata on cfg_we)
//
// One number at a time; in_ch.ready is high only when idle.
// Each odd p up to number/2 costs a prime test of p and, if prime, of number-p;
// each test runs one remainder pass per odd divisor up to its root.
// Pairs are buffered, then sent one word at a time, each held until out_ch.ready.
// Synchronous active-low reset; no clearing pass.
module goldbach_partition_finder import gpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gpf_in_if.sink    in_ch,
  gpf_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_NEXT   = 7'b0000010,
    S_TEST_P = 7'b0000100,
    S_TEST_Q = 7'b0001000,
    S_RD     = 7'b0010000,
    S_LOAD   = 7'b0100000,
    S_SEND   = 7'b1000000
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic       first_only_r;
  value_t     num_r, num_nxt;
  value_t     p_r, p_nxt;
  count_t     count_r, count_nxt;
  count_t     idx_r, idx_nxt;
  logic       cut_r, cut_nxt;
  value_t     q;

  value_t     mem [MAX_PAIRS];
  value_t     rd_data_r;
  logic       mem_we;

  logic       pt_start;
  value_t     pt_value;
  logic       pt_done;
  logic       pt_prime;

  logic       out_valid_r, out_valid_nxt;
  value_t     out_small_r, out_small_nxt;
  value_t     out_large_r, out_large_nxt;
  logic       out_found_r, out_found_nxt;
  logic       out_trunc_r, out_trunc_nxt;
  logic       out_last_r, out_last_nxt;

  assign q = num_r - p_r;

  gpf_prime_test u_prime (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pt_start),
    .value    (pt_value),
    .done     (pt_done),
    .is_prime (pt_prime)
  );

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    p_nxt         = p_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cut_nxt       = cut_r;
    mem_we        = 1'b0;
    pt_start      = 1'b0;
    pt_value      = p_r;
    out_valid_nxt = out_valid_r;
    out_small_nxt = out_small_r;
    out_large_nxt = out_large_r;
    out_found_nxt = out_found_r;
    out_trunc_nxt = out_trunc_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          num_nxt   = in_ch.number;
          p_nxt     = value_t'(3);
          count_nxt = '0;
          idx_nxt   = '0;
          cut_nxt   = 1'b0;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (p_r > (num_r >> 1)) begin
          state_nxt = S_RD;
        end else begin
          pt_start  = 1'b1;
          state_nxt = S_TEST_P;
        end
      end
      S_TEST_P: begin
        if (pt_done) begin
          if (pt_prime) begin
            pt_start  = 1'b1;
            pt_value  = q;
            state_nxt = S_TEST_Q;
          end else begin
            p_nxt     = p_r + value_t'(2);
            state_nxt = S_NEXT;
          end
        end
      end
      S_TEST_Q: begin
        if (pt_done) begin
          if (pt_prime) begin
            if (count_r == count_t'(MAX_PAIRS)) begin
              cut_nxt   = 1'b1;
              state_nxt = S_RD;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
              p_nxt     = p_r + value_t'(2);
              state_nxt = first_only_r ? S_RD : S_NEXT;
            end
          end else begin
            p_nxt     = p_r + value_t'(2);
            state_nxt = S_NEXT;
          end
        end
      end
      S_RD: state_nxt = S_LOAD;
      S_LOAD: begin
        out_valid_nxt = 1'b1;
        if (count_r == '0) begin
          out_small_nxt = '0;
          out_large_nxt = '0;
          out_found_nxt = 1'b0;
          out_trunc_nxt = 1'b0;
          out_last_nxt  = 1'b1;
        end else begin
          out_small_nxt = rd_data_r;
          out_large_nxt = num_r - rd_data_r;
          out_found_nxt = 1'b1;
          out_trunc_nxt = cut_r;
          out_last_nxt  = (idx_r + 1'b1) == count_r;
        end
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= p_r;
    end
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_only_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        first_only_r <= cfg_wdata;
      end
    end
    num_r       <= num_nxt;
    p_r         <= p_nxt;
    count_r     <= count_nxt;
    idx_r       <= idx_nxt;
    cut_r       <= cut_nxt;
    out_small_r <= out_small_nxt;
    out_large_r <= out_large_nxt;
    out_found_r <= out_found_nxt;
    out_trunc_r <= out_trunc_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.number_echo = num_r;
  assign out_ch.small_prime = out_small_r;
  assign out_ch.large_prime = out_large_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.truncated   = out_trunc_r;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire
